// ===== rtl/dps_pkg.sv =====
// Shared types and constants for the dynamic priority scheduler.
package dps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QCOUNT_W    = 5;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] ST_REQUEUED = 3'd0;
    localparam logic [2:0] ST_FINISHED = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_ADDED    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_ZERO     = 3'd5;

    localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] prio;
        logic [15:0]        run;
        logic [15:0]        need;
    } entry_t;

    typedef enum logic [1:0] {
        SEL_REQ,
        SEL_HEAD,
        SEL_HELD,
        SEL_ZERO
    } out_sel_t;

    typedef struct packed {
        logic       ins_req;
        logic       ins_held;
        logic       pop;
        logic       load_held;
        logic       load_out;
        logic [2:0] st;
        out_sel_t   sel;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic zero_need;
        logic done;
        logic out_busy;
    } sts_t;

endpackage

// ===== rtl/dynamic_priority_scheduler_core.sv =====
// Top level of the dynamic priority scheduler: controller plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | opcode, proc_id, priority_req, needed_time
//  out     | out_valid / out_stall| status, out_proc_id, out_priority,
//          |                      | out_run_time, out_needed_time, queue_count
//
// An add, or a tick that finishes its process or finds the queue empty, completes
// from idle; a tick that requeues its process enters a requeue state for the sorted
// reinsertion. The queue is a row of shift cells that insert and pop move at once.
// in_stall is high while a requeue is in progress or a result waits under out_stall.
// Reset empties the queue and drops any pending result; queue cells hold no reset.
module dynamic_priority_scheduler_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [7:0]         proc_id,
    input  logic signed [15:0] priority_req,
    input  logic [15:0]        needed_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [7:0]         out_proc_id,
    output logic signed [15:0] out_priority,
    output logic [15:0]        out_run_time,
    output logic [15:0]        out_needed_time,
    output logic [4:0]         queue_count
);

    dps_pkg::cmd_t cmd;
    dps_pkg::sts_t sts;

    dps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    dps_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .proc_id         (proc_id),
        .priority_req    (priority_req),
        .needed_time     (needed_time),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .out_proc_id     (out_proc_id),
        .out_priority    (out_priority),
        .out_run_time    (out_run_time),
        .out_needed_time (out_needed_time),
        .queue_count     (queue_count)
    );

endmodule

// ===== rtl/dps_ctrl.sv =====
// Controller state machine: sequences add, pop and requeue steps.
module dps_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          opcode,
    input  dps_pkg::sts_t sts,
    output dps_pkg::cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_REQUEUE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE) || sts.out_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = dps_pkg::SEL_REQ;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == dps_pkg::OP_ADD)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.sel      = dps_pkg::SEL_REQ;
                        if (sts.full)
                            cmd.st = dps_pkg::ST_FULL;
                        else if (sts.zero_need)
                            cmd.st = dps_pkg::ST_ZERO;
                        else
                        begin
                            cmd.ins_req = 1'b1;
                            cmd.st      = dps_pkg::ST_ADDED;
                        end
                    end
                    else if (sts.empty)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.st       = dps_pkg::ST_IDLE;
                        cmd.sel      = dps_pkg::SEL_ZERO;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                        if (sts.done)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.st       = dps_pkg::ST_FINISHED;
                            cmd.sel      = dps_pkg::SEL_HEAD;
                        end
                        else
                        begin
                            // hold the aged head for reinsertion next cycle
                            cmd.load_held = 1'b1;
                            state_next    = S_REQUEUE;
                        end
                    end
                end
            end
            S_REQUEUE:
            begin
                cmd.ins_held = 1'b1;
                cmd.load_out = 1'b1;
                cmd.st       = dps_pkg::ST_REQUEUED;
                cmd.sel      = dps_pkg::SEL_HELD;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/dps_datapath.sv =====
// Datapath: sorted shift-register queue, held entry and output register.
module dps_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          proc_id,
    input  logic signed [15:0]  priority_req,
    input  logic [15:0]         needed_time,
    input  dps_pkg::cmd_t       cmd,
    output dps_pkg::sts_t       sts,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [7:0]          out_proc_id,
    output logic signed [15:0]  out_priority,
    output logic [15:0]         out_run_time,
    output logic [15:0]         out_needed_time,
    output logic [4:0]          queue_count
);

    localparam int DEPTH = dps_pkg::QUEUE_DEPTH;
    localparam int CW    = dps_pkg::CNT_W;
    localparam int QW    = dps_pkg::QCOUNT_W;

    dps_pkg::entry_t entry_reg [DEPTH];
    dps_pkg::entry_t entry_next [DEPTH];
    dps_pkg::entry_t held_reg;
    dps_pkg::entry_t req_entry;
    dps_pkg::entry_t head_upd;
    dps_pkg::entry_t aged;
    dps_pkg::entry_t ins_entry;
    dps_pkg::entry_t out_entry;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW+QW-1:0] count_ext;
    logic [DEPTH-1:0] keep;
    logic            out_valid_reg;
    logic [2:0]      status_reg;
    dps_pkg::entry_t out_entry_reg;
    logic [QW-1:0]   qcount_reg;

    always_comb
    begin
        req_entry.id   = proc_id;
        req_entry.prio = priority_req;
        req_entry.run  = 16'd0;
        req_entry.need = needed_time;

        head_upd     = entry_reg[0];
        head_upd.run = entry_reg[0].run + 16'd1;

        aged = head_upd;
        if (head_upd.prio != dps_pkg::PRIO_MIN)
            aged.prio = head_upd.prio - 16'sd1;
    end

    assign sts.full      = (count_reg >= CW'(DEPTH));
    assign sts.empty     = (count_reg == '0);
    assign sts.zero_need = (needed_time == 16'd0);
    assign sts.done      = (head_upd.run == head_upd.need);
    assign sts.out_busy  = out_valid_reg && out_stall;

    assign ins_entry = cmd.ins_held ? held_reg : req_entry;

    // cells holding priority >= new entry stay; the first other takes it, the rest shift down
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            keep[i] = (CW'(i) < count_reg) && (entry_reg[i].prio >= ins_entry.prio);

        for (int i = 0; i < DEPTH; i++)
            entry_next[i] = entry_reg[i];

        if (cmd.ins_req || cmd.ins_held)
        begin
            if (!keep[0])
                entry_next[0] = ins_entry;
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!keep[i])
                    entry_next[i] = keep[i-1] ? ins_entry : entry_reg[i-1];
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
                entry_next[i] = entry_reg[i+1];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_req || cmd.ins_held)
            count_next = count_reg + CW'(1);
        else if (cmd.pop)
            count_next = count_reg - CW'(1);
    end

    assign count_ext = {{QW{1'b0}}, count_next};

    always_comb
    begin
        case (cmd.sel)
            dps_pkg::SEL_REQ:  out_entry = req_entry;
            dps_pkg::SEL_HEAD: out_entry = head_upd;
            dps_pkg::SEL_HELD: out_entry = held_reg;
            dps_pkg::SEL_ZERO: out_entry = '0;
            default:           out_entry = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            entry_reg[i] <= entry_next[i];
        if (cmd.load_held)
            held_reg <= aged;
        if (cmd.load_out)
        begin
            status_reg    <= cmd.st;
            out_entry_reg <= out_entry;
            qcount_reg    <= count_ext[QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign out_proc_id     = out_entry_reg.id;
    assign out_priority    = out_entry_reg.prio;
    assign out_run_time    = out_entry_reg.run;
    assign out_needed_time = out_entry_reg.need;
    assign queue_count     = qcount_reg;

endmodule

// ===== rtl/dps_checker.sv =====
// Port-level checks for the dynamic priority scheduler, bound to the top level.
module dps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         status,
    input logic [7:0]         out_proc_id,
    input logic signed [15:0] out_priority,
    input logic [15:0]        out_run_time,
    input logic [15:0]        out_needed_time,
    input logic [4:0]         queue_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_proc_id)
            && $stable(out_priority) && $stable(queue_count))
        else $error("stalled result changed");

    a_finish_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dps_pkg::ST_FINISHED) |-> out_run_time == out_needed_time)
        else $error("finished process run time differs from needed time");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dps_pkg::ST_IDLE) |-> queue_count == 5'd0
            && out_proc_id == 8'd0 && out_needed_time == 16'd0)
        else $error("idle result not empty");

    a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dps_pkg::ST_ADDED || status == dps_pkg::ST_REQUEUED)
            |-> queue_count != 5'd0)
        else $error("insert reported with an empty queue");

    // a result waiting under stall blocks further transfers in
    a_block_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall || !in_valid)
        else $error("input taken while result is stalled");

endmodule

bind dynamic_priority_scheduler_core dps_checker u_dps_checker (.*);
